// File: rtl/block_transfer_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Block transfer sequencer assertion macros
// Shared concurrent assertion forms used by the sequencer modules.
// ----------------------------------------------------------------------------
`ifndef BLOCK_TRANSFER_SEQUENCER_MACROS_SVH
`define BLOCK_TRANSFER_SEQUENCER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("block transfer sequencer: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("block transfer sequencer: assertion failed");

`endif

// File: rtl/bts_pkg.sv
// ----------------------------------------------------------------------------
// Block transfer sequencer package
// Shared constants, command and result types for the sequencer modules.
// ----------------------------------------------------------------------------
package bts_pkg;

   // Command queue geometry.
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   // Processor mode codes.
   localparam logic [4:0] MODE_USR = 5'h10;
   localparam logic [4:0] MODE_FIQ = 5'h11;
   localparam logic [4:0] MODE_SYS = 5'h1F;

   // Register numbers.
   localparam logic [3:0] REG_PC       = 4'd15;
   localparam logic [3:0] REG_FIQ_LOW  = 4'd8;
   localparam logic [3:0] REG_BANK_LOW = 4'd13;

   // Core selection.
   localparam logic CORE_ARM9 = 1'b0;
   localparam logic CORE_ARM7 = 1'b1;

   // Opcode.
   localparam logic OP_STORE = 1'b0;
   localparam logic OP_LOAD  = 1'b1;

   // Store data source codes.
   localparam logic [1:0] SRC_REG  = 2'd0;
   localparam logic [1:0] SRC_BASE = 2'd1;
   localparam logic [1:0] SRC_ADDR = 2'd2;

   // Span of an empty list and the list that stands in for it.
   localparam logic [6:0]  EMPTY_SPAN    = 7'h40;
   localparam logic [6:0]  WORD_STEP     = 7'd4;
   localparam logic [15:0] PC_ONLY_LIST  = 16'h8000;

   // Back end sequencer states.
   typedef enum logic {
      BTS_IDLE,
      BTS_RUN
   } seq_state_type;

   // One classified instruction, as queued between front and back.
   typedef struct packed {
      logic        load;
      logic        arm7;
      logic        empty;
      logic        sb;
      logic        banked;
      logic        load_user;
      logic        base_lowest;
      logic        wb_en;
      logic [3:0]  bidx;
      logic [15:0] list;
      logic [31:0] first_addr;
      logic [31:0] wb_value;
   } cmd_type;

   // One result item.
   typedef struct packed {
      logic        transfer_valid;
      logic [31:0] address;
      logic [3:0]  reg_index;
      logic        sequential;
      logic        user_bank;
      logic [1:0]  store_source;
      logic        pc_plus_four;
      logic        pc_clear_bit0;
      logic        restore_status;
      logic        wb_enable;
      logic [31:0] wb_value;
      logic        last;
   } rsp_type;

endpackage

// File: rtl/bts_front.sv
// ----------------------------------------------------------------------------
// Block transfer sequencer front end
// Accepts instruction beats, holds the core selection register and
// classifies each instruction into a command for the queue.
// ----------------------------------------------------------------------------
module bts_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data,
   input  logic             req_tvalid,
   output logic             req_tready,
   // reg_list[15:0], base_index[19:16], base_value[51:20], pre_index[52],
   // up_dir[53], write_back[54], s_bit[55], cpu_mode[60:56], zero[63:61]
   input  logic [63:0]      req_tdata,
   // opcode[0]
   input  logic [0:0]       req_tuser,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output bts_pkg::cmd_type cmd
);
   import bts_pkg::*;

   logic        core_kind_ff;
   logic        core_kind_in;
   logic        load;
   logic [15:0] list;
   logic [3:0]  bidx;
   logic [31:0] base;
   logic        pre;
   logic        up;
   logic        wb;
   logic        sb;
   logic [4:0]  mode;
   logic        arm7;
   logic        empty;
   logic [2:0]  nib_cnt [4];
   logic [4:0]  count;
   logic [6:0]  span;
   logic [6:0]  desc_off;
   logic [31:0] asc_first;
   logic [31:0] desc_first;
   logic [15:0] base_onehot;
   logic [15:0] below_mask;
   logic [15:0] above_mask;
   logic        base_listed;
   logic        only_base;
   logic        higher_listed;
   logic        banked;
   logic        wb_en;

   // Core selection register.
   always_comb begin
      core_kind_in = core_kind_ff;
      if (csr_valid && csr_ready) begin
         core_kind_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         core_kind_ff <= CORE_ARM9;
      end else begin
         core_kind_ff <= core_kind_in;
      end
   end

   assign csr_ready = 1'b1;

   // Field unpacking.
   assign load = req_tuser[0];
   assign list = req_tdata[15:0];
   assign bidx = req_tdata[19:16];
   assign base = req_tdata[51:20];
   assign pre  = req_tdata[52];
   assign up   = req_tdata[53];
   assign wb   = req_tdata[54];
   assign sb   = req_tdata[55];
   assign mode = req_tdata[60:56];
   assign arm7 = (core_kind_ff == CORE_ARM7);
   assign empty = (list == 16'd0);

   // Register count as a sum of nibble counts.
   always_comb begin
      for (int n = 0; n < 4; n++) begin
         nib_cnt[n] = 3'(list[4*n]) + 3'(list[4*n+1]) + 3'(list[4*n+2])
                    + 3'(list[4*n+3]);
      end
      count = 5'(nib_cnt[0]) + 5'(nib_cnt[1]) + 5'(nib_cnt[2]) + 5'(nib_cnt[3]);
   end

   // Byte span of the transfer; an empty list covers sixteen words.
   assign span = empty ? EMPTY_SPAN : {count, 2'b00};

   // First access address. Ascending steps once when pre-indexed; descending
   // starts at base - span and steps once when post-indexed.
   assign desc_off   = pre ? span : (span - WORD_STEP);
   assign asc_first  = base + {29'd0, pre, 2'b00};
   assign desc_first = base - {25'd0, desc_off};

   // Position of the base register within the list.
   assign base_onehot   = 16'd1 << bidx;
   assign below_mask    = base_onehot - 16'd1;
   assign above_mask    = ~(below_mask | base_onehot);
   assign base_listed   = |(list & base_onehot);
   assign only_base     = ((list & ~base_onehot) == 16'd0);
   assign higher_listed = |(list & above_mask);

   // A base that lives in a banked register is stored from the user bank.
   always_comb begin
      banked = 1'b0;
      if (sb) begin
         if (mode == MODE_FIQ) begin
            banked = (bidx >= REG_FIQ_LOW) && (bidx != REG_PC);
         end else if ((mode != MODE_USR) && (mode != MODE_SYS)) begin
            banked = (bidx >= REG_BANK_LOW) && (bidx != REG_PC);
         end
      end
   end

   // Writeback rule for a load that also loads the base.
   always_comb begin
      wb_en = wb;
      if (!empty && (load == OP_LOAD) && wb && base_listed) begin
         wb_en = arm7 ? 1'b0 : (only_base || higher_listed);
      end
   end

   // Command assembly.
   always_comb begin
      cmd.load        = load;
      cmd.arm7        = arm7;
      cmd.empty       = empty;
      cmd.sb          = sb;
      cmd.banked      = banked;
      cmd.load_user   = sb && !list[15];
      cmd.base_lowest = ((list & below_mask) == 16'd0);
      cmd.wb_en       = wb_en;
      cmd.bidx        = bidx;
      cmd.list        = empty ? PC_ONLY_LIST : list;
      cmd.first_addr  = up ? asc_first : desc_first;
      cmd.wb_value    = up ? (base + {25'd0, span}) : (base - {25'd0, span});
   end

   assign cmd_valid  = req_tvalid;
   assign req_tready = cmd_ready;

endmodule

// File: rtl/bts_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Block transfer sequencer command queue
// Short queue of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
`include "block_transfer_sequencer_macros.svh"

module bts_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  bts_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output bts_pkg::cmd_type out_cmd
);
   import bts_pkg::*;

   cmd_type                entries_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff;
   logic [CMD_PTR_W-1:0]   wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff;
   logic [CMD_PTR_W-1:0]   rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff;
   logic [CMD_CNT_W-1:0]   count_in;
   logic                   push;
   logic                   pop;

   assign in_ready  = (count_ff != CMD_CNT_W'(CMD_DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_cmd   = entries_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                                                              : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                                                              : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_cmd;
      end
   end

   // Occupancy never exceeds the queue depth.
   `BTS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CMD_CNT_W'(CMD_DEPTH))
   // A push without a pop grows the queue by exactly one entry.
   `BTS_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop, count_ff == CMD_CNT_W'($past(count_ff) + 1'b1))
   // A pop without a push shrinks the queue by exactly one entry.
   `BTS_ASSERT_NEXT(a_pop_shrinks, clock, reset, pop && !push, count_ff == CMD_CNT_W'($past(count_ff) - 1'b1))

endmodule

// File: rtl/bts_back.sv
// ----------------------------------------------------------------------------
// Block transfer sequencer back end
// Walks the register list of one command, one transfer per cycle while the result
// slot is free or being taken, and drives the registered result channel.
// ----------------------------------------------------------------------------
`include "block_transfer_sequencer_macros.svh"

module bts_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  bts_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bts_pkg::rsp_type rsp
);
   import bts_pkg::*;

   seq_state_type state_ff;
   seq_state_type state_in;
   cmd_type       cur_ff;
   cmd_type       cur_in;
   logic [15:0]   mask_ff;
   logic [15:0]   mask_in;
   logic [31:0]   addr_ff;
   logic [31:0]   addr_in;
   logic          seq_ff;
   logic          seq_in;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          load_cmd;
   logic          step;
   logic [15:0]   low_onehot;
   logic [15:0]   mask_rest;
   logic [3:0]    idx;
   logic          is_last;
   logic          is_pc;
   logic          is_base_store;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BTS_IDLE: begin
            if (cmd_valid) begin
               state_in = BTS_RUN;
            end
         end
         BTS_RUN: begin
            if (step && is_last) begin
               state_in = BTS_IDLE;
            end
         end
         default: begin
            state_in = BTS_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      load_cmd  = 1'b0;
      step      = 1'b0;
      cmd_ready = 1'b0;
      case (state_ff)
         BTS_IDLE: begin
            cmd_ready = 1'b1;
            load_cmd  = cmd_valid;
         end
         BTS_RUN: begin
            step = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            cmd_ready = 1'b0;
         end
      endcase
   end

   // Lowest remaining register.
   assign low_onehot = mask_ff & (~mask_ff + 16'd1);
   assign mask_rest  = mask_ff & ~low_onehot;
   assign is_last    = (mask_rest == 16'd0);

   always_comb begin
      idx = 4'd0;
      for (int i = 0; i < 16; i++) begin
         idx = idx | ({4{low_onehot[i]}} & 4'(i));
      end
   end

   assign is_pc         = (idx == REG_PC);
   assign is_base_store = (idx == cur_ff.bidx) && !cur_ff.banked && !cur_ff.empty;

   // Result item for the current register.
   always_comb begin
      rsp_in                = '0;
      rsp_in.last           = is_last;
      rsp_in.wb_enable      = is_last && cur_ff.wb_en;
      rsp_in.wb_value       = (is_last && cur_ff.wb_en) ? cur_ff.wb_value : 32'd0;
      if (!(cur_ff.empty && !cur_ff.arm7)) begin
         rsp_in.transfer_valid = 1'b1;
         rsp_in.address        = addr_ff;
         rsp_in.reg_index      = idx;
         rsp_in.sequential     = seq_ff;
         if (cur_ff.load == OP_LOAD) begin
            if (is_pc) begin
               rsp_in.pc_clear_bit0  = cur_ff.arm7;
               rsp_in.restore_status = cur_ff.sb;
            end else begin
               rsp_in.user_bank = cur_ff.load_user;
            end
         end else if (is_base_store) begin
            rsp_in.store_source = (!cur_ff.arm7 || cur_ff.base_lowest) ? SRC_BASE
                                                                       : SRC_ADDR;
         end else begin
            rsp_in.store_source = SRC_REG;
            rsp_in.user_bank    = cur_ff.sb && !cur_ff.empty;
            rsp_in.pc_plus_four = is_pc && cur_ff.arm7;
         end
      end
   end

   // Sequencer registers.
   always_comb begin
      cur_in  = cur_ff;
      mask_in = mask_ff;
      addr_in = addr_ff;
      seq_in  = seq_ff;
      if (load_cmd) begin
         cur_in  = cmd;
         mask_in = cmd.list;
         addr_in = cmd.first_addr;
         seq_in  = 1'b0;
      end else if (step) begin
         mask_in = mask_rest;
         addr_in = addr_ff + 32'd4;
         seq_in  = 1'b1;
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BTS_IDLE;
         mask_ff      <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      addr_ff <= addr_in;
      seq_ff  <= seq_in;
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // While running there is always a register left to transfer.
   `BTS_ASSERT_NOW(a_run_has_work, clock, reset, state_ff == BTS_RUN, mask_ff != 16'd0)
   // The final transfer of a command returns the sequencer to idle.
   `BTS_ASSERT_NEXT(a_last_to_idle, clock, reset, step && is_last, state_ff == BTS_IDLE)
   // Writeback is only ever reported on the final beat.
   `BTS_ASSERT_NOW(a_wb_on_last, clock, reset, rsp_valid_ff && !rsp_ff.last, !rsp_ff.wb_enable)

endmodule

// File: rtl/block_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// Block transfer sequencer
// Expands one load or store multiple instruction into one transfer beat per
// listed register, with addresses, bank and store-source controls, and the
// base writeback on the final beat.
// ----------------------------------------------------------------------------
// Timing: a request beat goes into the two-entry command queue, then into the back
// end sequencer registers, which register each result beat. The back end moves one
// register per cycle unless the result slot is held by rsp_tready, walking one beat per
// listed register (one for an empty list), and takes the next command only when idle.
// Reset: synchronous; selects ARM9 rules, empties the queue and result slot.
// ----------------------------------------------------------------------------
module block_transfer_sequencer (
   input  logic        clock,
   input  logic        reset,
   // Configuration: core_kind[0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data,
   // Instruction beats
   input  logic        req_tvalid,
   output logic        req_tready,
   // reg_list[15:0], base_index[19:16], base_value[51:20], pre_index[52],
   // up_dir[53], write_back[54], s_bit[55], cpu_mode[60:56], zero[63:61]
   input  logic [63:0] req_tdata,
   // opcode[0]
   input  logic [0:0]  req_tuser,
   // Transfer beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // address[31:0], reg_index[35:32], sequential[36], user_bank[37],
   // store_source[39:38], pc_plus_four[40], pc_clear_bit0[41],
   // restore_status[42], wb_enable[43], wb_value[75:44], zero[79:76]
   output logic [79:0] rsp_tdata,
   // transfer_valid[0]
   output logic [0:0]  rsp_tuser,
   output logic        rsp_tlast
);
   import bts_pkg::*;

   cmd_type front_cmd;
   logic    front_valid;
   logic    front_ready;
   cmd_type queue_cmd;
   logic    queue_valid;
   logic    queue_ready;
   rsp_type rsp;

   // Accept and classify.
   bts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .cmd        (front_cmd)
   );

   // Command queue between the two halves.
   bts_cmd_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_cmd   (queue_cmd)
   );

   // Register walk and result channel.
   bts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .cmd       (queue_cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // Result beat packing.
   assign rsp_tdata = {4'd0, rsp.wb_value, rsp.wb_enable, rsp.restore_status,
                       rsp.pc_clear_bit0, rsp.pc_plus_four, rsp.store_source,
                       rsp.user_bank, rsp.sequential, rsp.reg_index, rsp.address};
   assign rsp_tuser = rsp.transfer_valid;
   assign rsp_tlast = rsp.last;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block transfer sequencer testbench
// Drives load and store multiple instructions into the sequencer, expands each
// one in a local model of the address sequence, and checks every transfer
// beat field by field. A directed table covers empty lists, full lists, base
// in list, banked bases and PC transfers under both core rules; random phases
// follow with both cores, random idling on both sides and one long stall.
// ----------------------------------------------------------------------------
module tb;
   import bts_pkg::*;

   // Privileged mode codes that the package does not name.
   localparam logic [4:0] MODE_IRQ = 5'h12;
   localparam logic [4:0] MODE_SVC = 5'h13;
   localparam logic [4:0] MODE_ABT = 5'h17;
   localparam logic [4:0] MODE_UND = 5'h1B;

   localparam int LONG_HOLD = 150;
   localparam int MAX_SHOWN = 10;

   // One block transfer instruction as offered on the request side.
   typedef struct packed {
      logic        op;
      logic [15:0] list;
      logic [3:0]  bidx;
      logic [31:0] base;
      logic        pre;
      logic        up;
      logic        wb;
      logic        sb;
      logic [4:0]  mode;
   } instr_type;

   // One row of the directed table; beat is used only when typed is set.
   typedef struct packed {
      logic      core;
      instr_type instr;
      logic      typed;
      rsp_type   beat;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;

   rsp_type     pending_transfers[$];
   dir_row_type directed_rows[$];
   logic        core_sel;
   int          mismatch_count;
   int          idle_pct;
   logic        long_hold_req;

   block_transfer_sequencer u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 100 MHz clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Build an instruction from its fields.
   function automatic instr_type blk(input logic op, input logic [15:0] list,
                                     input logic [3:0] bidx, input logic [31:0] base,
                                     input logic pre, input logic up, input logic wb,
                                     input logic sb, input logic [4:0] mode);
      instr_type b;
      b.op = op;
      b.list = list;
      b.bidx = bidx;
      b.base = base;
      b.pre = pre;
      b.up = up;
      b.wb = wb;
      b.sb = sb;
      b.mode = mode;
      return b;
   endfunction

   // Build a single final beat for the rows whose result is read off directly.
   function automatic rsp_type final_beat(input logic valid, input logic [31:0] addr,
                                          input logic [3:0] rix, input logic [1:0] src,
                                          input logic p4, input logic clr0,
                                          input logic rest, input logic wbe,
                                          input logic [31:0] wbv);
      rsp_type r;
      r = '0;
      r.transfer_valid = valid;
      r.address = addr;
      r.reg_index = rix;
      r.store_source = src;
      r.pc_plus_four = p4;
      r.pc_clear_bit0 = clr0;
      r.restore_status = rest;
      r.wb_enable = wbe;
      r.wb_value = wbv;
      r.last = 1'b1;
      return r;
   endfunction

   task automatic add_row(input logic core, input instr_type b, input logic typed,
                          input rsp_type beat);
      dir_row_type row;
      row.core = core;
      row.instr = b;
      row.typed = typed;
      row.beat = beat;
      directed_rows.push_back(row);
   endtask

   // Expand one instruction into its transfer beats under the current core rules.
   task automatic expand_block(input instr_type b);
      rsp_type     cur;
      rsp_type     prev;
      logic        have_prev;
      logic        arm7;
      logic        step_first;
      logic        banked;
      logic        load_user;
      logic        lowest;
      logic        only_base;
      logic        higher;
      logic        wb_en;
      logic [31:0] addr;
      logic [31:0] span;
      logic [31:0] wbv;
      arm7 = (core_sel == CORE_ARM7);
      // Empty list: writeback only on ARM9, a lone PC access on ARM7.
      if (b.list == 16'h0) begin
         wbv = b.up ? b.base + EMPTY_SPAN : b.base - EMPTY_SPAN;
         cur = '0;
         if (arm7) begin
            cur.transfer_valid = 1'b1;
            cur.address = (b.up ? b.base : wbv) + ((b.pre == b.up) ? WORD_STEP : 7'd0);
            cur.reg_index = REG_PC;
            if (b.op == OP_LOAD) begin
               cur.pc_clear_bit0 = 1'b1;
               cur.restore_status = b.sb;
            end else begin
               cur.pc_plus_four = 1'b1;
            end
         end
         cur.wb_enable = b.wb;
         cur.wb_value = b.wb ? wbv : 32'h0;
         cur.last = 1'b1;
         pending_transfers.push_back(cur);
         return;
      end
      span = 32'h0;
      for (int i = 0; i < 16; i++) begin
         if (b.list[i]) span += 32'd4;
      end
      addr = b.up ? b.base : b.base - span;
      wbv = b.up ? b.base + span : b.base - span;
      step_first = b.up ? b.pre : !b.pre;
      // A banked base stores the user copy rather than the original base.
      banked = 1'b0;
      if (b.sb) begin
         if (b.mode == MODE_FIQ)
            banked = (b.bidx >= REG_FIQ_LOW) && (b.bidx < REG_PC);
         else if (b.mode != MODE_USR && b.mode != MODE_SYS)
            banked = (b.bidx >= REG_BANK_LOW) && (b.bidx < REG_PC);
      end
      load_user = b.sb && !b.list[15];
      have_prev = 1'b0;
      prev = '0;
      for (int i = 0; i < 16; i++) begin
         if (b.list[i]) begin
            if (step_first) addr += 32'd4;
            cur = '0;
            cur.transfer_valid = 1'b1;
            cur.address = addr;
            cur.reg_index = i[3:0];
            cur.sequential = have_prev;
            if (b.op == OP_LOAD) begin
               if (i == 15) begin
                  cur.pc_clear_bit0 = arm7;
                  cur.restore_status = b.sb;
               end else begin
                  cur.user_bank = load_user;
               end
            end else if (i == b.bidx && !banked) begin
               lowest = ({16'h0, b.list} & ((32'd1 << i) - 32'd1)) == 32'h0;
               cur.store_source = (!arm7 || lowest) ? SRC_BASE : SRC_ADDR;
            end else begin
               cur.user_bank = b.sb;
               cur.pc_plus_four = (i == 15) && arm7;
            end
            if (!step_first) addr += 32'd4;
            if (have_prev) pending_transfers.push_back(prev);
            prev = cur;
            have_prev = 1'b1;
         end
      end
      // Base writeback rules for a load whose base is also in the list.
      wb_en = b.wb;
      if (b.op == OP_LOAD && b.wb && b.list[b.bidx]) begin
         if (arm7) begin
            wb_en = 1'b0;
         end else begin
            only_base = ({16'h0, b.list} & ~(32'd1 << b.bidx)) == 32'h0;
            higher = ({16'h0, b.list} & ~((32'd2 << b.bidx) - 32'd1)) != 32'h0;
            wb_en = only_base || higher;
         end
      end
      prev.wb_enable = wb_en;
      prev.wb_value = wb_en ? wbv : 32'h0;
      prev.last = 1'b1;
      pending_transfers.push_back(prev);
   endtask

   function automatic instr_type random_block();
      instr_type b;
      int        pick;
      int        n;
      b.op = 1'($urandom_range(1));
      pick = $urandom_range(99);
      // Mostly short lists, some dense patterns and some empty ones.
      if (pick < 8) begin
         b.list = 16'h0;
      end else if (pick < 22) begin
         b.list = 16'($urandom);
      end else begin
         b.list = 16'h0;
         n = $urandom_range(1, 4);
         repeat (n) b.list[4'($urandom_range(15))] = 1'b1;
      end
      // Half the time the base is one of the listed registers.
      if (b.list != 16'h0 && $urandom_range(1) == 1) begin
         do b.bidx = 4'($urandom_range(15)); while (!b.list[b.bidx]);
      end else begin
         b.bidx = 4'($urandom_range(15));
      end
      // Bases near both ends of the address space exercise wraparound.
      case ($urandom_range(9))
         0: b.base = 32'hFFFF_FFC0 + ($urandom_range(15) << 2);
         1: b.base = $urandom_range(15) << 2;
         default: b.base = $urandom;
      endcase
      b.pre = 1'($urandom_range(1));
      b.up = 1'($urandom_range(1));
      b.wb = 1'($urandom_range(1));
      b.sb = 1'($urandom_range(1));
      if ($urandom_range(99) < 80) begin
         case ($urandom_range(6))
            0: b.mode = MODE_USR;
            1: b.mode = MODE_FIQ;
            2: b.mode = MODE_SYS;
            3: b.mode = MODE_IRQ;
            4: b.mode = MODE_SVC;
            5: b.mode = MODE_ABT;
            default: b.mode = MODE_UND;
         endcase
      end else begin
         b.mode = 5'($urandom_range(31));
      end
      return b;
   endfunction

   // Offer one instruction beat and record its expected transfers on acceptance.
   task automatic send_block(input instr_type b, input logic typed, input rsp_type beat);
      req_tvalid <= 1'b1;
      req_tuser <= b.op;
      req_tdata <= {3'b000, b.mode, b.sb, b.wb, b.up, b.pre, b.base, b.bidx, b.list};
      do @(posedge clock); while (!req_tready);
      if (typed)
         pending_transfers.push_back(beat);
      else
         expand_block(b);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every expected beat has arrived.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_transfers.size() != 0) @(posedge clock);
   endtask

   task automatic write_core(input logic kind);
      csr_valid <= 1'b1;
      csr_data <= kind;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      core_sel = kind;
   endtask

   function automatic string show_beat(input rsp_type r);
      return $sformatf({"v=%0b a=%h r=%0d s=%0b u=%0b src=%0d p4=%0b c0=%0b rs=%0b",
                        " wb=%0b/%h l=%0b"},
                       r.transfer_valid, r.address, r.reg_index, r.sequential,
                       r.user_bank, r.store_source, r.pc_plus_four, r.pc_clear_bit0,
                       r.restore_status, r.wb_enable, r.wb_value, r.last);
   endfunction

   function automatic string field_diffs(input rsp_type e, input rsp_type a);
      string s = "";
      if (e.transfer_valid !== a.transfer_valid) s = {s, " transfer_valid"};
      if (e.address !== a.address) s = {s, " address"};
      if (e.reg_index !== a.reg_index) s = {s, " reg_index"};
      if (e.sequential !== a.sequential) s = {s, " sequential"};
      if (e.user_bank !== a.user_bank) s = {s, " user_bank"};
      if (e.store_source !== a.store_source) s = {s, " store_source"};
      if (e.pc_plus_four !== a.pc_plus_four) s = {s, " pc_plus_four"};
      if (e.pc_clear_bit0 !== a.pc_clear_bit0) s = {s, " pc_clear_bit0"};
      if (e.restore_status !== a.restore_status) s = {s, " restore_status"};
      if (e.wb_enable !== a.wb_enable) s = {s, " wb_enable"};
      if (e.wb_value !== a.wb_value) s = {s, " wb_value"};
      if (e.last !== a.last) s = {s, " last"};
      return s;
   endfunction

   // Check every accepted transfer beat against the oldest expectation.
   always @(posedge clock) begin : beat_check
      rsp_type got;
      rsp_type want;
      string   diffs;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.transfer_valid = rsp_tuser[0];
         got.address = rsp_tdata[31:0];
         got.reg_index = rsp_tdata[35:32];
         got.sequential = rsp_tdata[36];
         got.user_bank = rsp_tdata[37];
         got.store_source = rsp_tdata[39:38];
         got.pc_plus_four = rsp_tdata[40];
         got.pc_clear_bit0 = rsp_tdata[41];
         got.restore_status = rsp_tdata[42];
         got.wb_enable = rsp_tdata[43];
         got.wb_value = rsp_tdata[75:44];
         got.last = rsp_tlast;
         if (pending_transfers.size() == 0) begin
            if (mismatch_count < MAX_SHOWN)
               $display("ERROR: unexpected transfer beat %s", show_beat(got));
            mismatch_count++;
         end else begin
            want = pending_transfers.pop_front();
            diffs = field_diffs(want, got);
            if (diffs != "") begin
               if (mismatch_count < MAX_SHOWN)
                  $display("ERROR: mismatch in%s\n  exp %s\n  got %s",
                           diffs, show_beat(want), show_beat(got));
               mismatch_count++;
            end
         end
      end
   end

   // Result side: random stall bursts, plus one long hold-off on request.
   initial begin : rsp_side
      int stall_left;
      rsp_tready = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0) rsp_tready <= 1'b1;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            stall_left = LONG_HOLD;
         end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(1, 13);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Hang guard.
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      dir_row_type row;
      int          n_items;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      core_sel = CORE_ARM9;
      mismatch_count = 0;
      idle_pct = 20;
      long_hold_req = 1'b0;

      // ARM9 rules, taken from reset.
      add_row(CORE_ARM9, blk(OP_STORE, 16'h0000, 4'd0, 32'h0000_1000, 0, 1, 1, 0, MODE_USR),
              1'b1, final_beat(0, 32'h0, 4'd0, SRC_REG, 0, 0, 0, 1, 32'h0000_1040));
      add_row(CORE_ARM9, blk(OP_LOAD, 16'h0000, 4'd7, 32'h0000_0000, 1, 0, 0, 1, MODE_SVC),
              1'b1, final_beat(0, 32'h0, 4'd0, SRC_REG, 0, 0, 0, 0, 32'h0));
      add_row(CORE_ARM9, blk(OP_LOAD, 16'h0001, 4'd0, 32'h0000_0100, 0, 1, 1, 0, MODE_USR),
              1'b1, final_beat(1, 32'h100, 4'd0, SRC_REG, 0, 0, 0, 1, 32'h0000_0104));
      add_row(CORE_ARM9, blk(OP_LOAD, 16'hFFFF, 4'd0, 32'hFFFF_FFFC, 1, 1, 1, 0, MODE_SYS),
              1'b0, '0);
      add_row(CORE_ARM9, blk(OP_STORE, 16'hFFFF, 4'd13, 32'h1234_5678, 0, 1, 1, 1, MODE_USR),
              1'b0, '0);
      add_row(CORE_ARM9, blk(OP_LOAD, 16'h00F0, 4'd5, 32'h0000_2000, 0, 1, 1, 0, MODE_SVC),
              1'b0, '0);
      add_row(CORE_ARM9, blk(OP_LOAD, 16'h0030, 4'd5, 32'h0000_2000, 0, 1, 1, 0, MODE_SVC),
              1'b0, '0);
      add_row(CORE_ARM9, blk(OP_STORE, 16'h0006, 4'd2, 32'h0000_3000, 1, 1, 1, 0, MODE_IRQ),
              1'b0, '0);
      add_row(CORE_ARM9, blk(OP_LOAD, 16'h8001, 4'd1, 32'h0000_4000, 0, 1, 0, 1, MODE_SVC),
              1'b0, '0);
      add_row(CORE_ARM9, blk(OP_LOAD, 16'h7FFF, 4'd3, 32'h0000_5000, 1, 0, 1, 1, MODE_FIQ),
              1'b0, '0);
      add_row(CORE_ARM9, blk(OP_STORE, 16'h0300, 4'd9, 32'h0000_6000, 0, 0, 1, 1, MODE_FIQ),
              1'b0, '0);
      add_row(CORE_ARM9, blk(OP_STORE, 16'h6000, 4'd13, 32'h0000_7000, 1, 0, 1, 1, MODE_SVC),
              1'b0, '0);
      add_row(CORE_ARM9, blk(OP_LOAD, 16'h000F, 4'd4, 32'h8000_0000, 1, 0, 1, 0, MODE_ABT),
              1'b0, '0);
      add_row(CORE_ARM9, blk(OP_STORE, 16'h8000, 4'd15, 32'h0000_0000, 0, 0, 1, 0, MODE_UND),
              1'b0, '0);
      add_row(CORE_ARM9, blk(OP_STORE, 16'hFFFF, 4'd14, 32'hAAAA_AAA8, 1, 1, 0, 1, 5'h00),
              1'b0, '0);
      // ARM7 rules.
      add_row(CORE_ARM7, blk(OP_LOAD, 16'h0000, 4'd2, 32'h0000_2000, 1, 1, 1, 1, MODE_SVC),
              1'b1, final_beat(1, 32'h0000_2004, REG_PC, SRC_REG, 0, 1, 1, 1, 32'h0000_2040));
      add_row(CORE_ARM7, blk(OP_STORE, 16'h0000, 4'd2, 32'h0000_0040, 0, 0, 0, 0, MODE_USR),
              1'b1, final_beat(1, 32'h0000_0004, REG_PC, SRC_REG, 1, 0, 0, 0, 32'h0));
      add_row(CORE_ARM7, blk(OP_STORE, 16'h8000, 4'd0, 32'h0000_0300, 0, 1, 0, 0, MODE_USR),
              1'b1, final_beat(1, 32'h0000_0300, REG_PC, SRC_REG, 1, 0, 0, 0, 32'h0));
      add_row(CORE_ARM7, blk(OP_STORE, 16'h000C, 4'd3, 32'h0000_0800, 0, 1, 1, 0, MODE_USR),
              1'b0, '0);
      add_row(CORE_ARM7, blk(OP_STORE, 16'h000C, 4'd2, 32'h0000_0800, 1, 0, 1, 0, MODE_SYS),
              1'b0, '0);
      add_row(CORE_ARM7, blk(OP_LOAD, 16'h0011, 4'd4, 32'h0000_0900, 0, 1, 1, 0, MODE_USR),
              1'b0, '0);
      add_row(CORE_ARM7, blk(OP_LOAD, 16'hFFFF, 4'd15, 32'hFFFF_FFFF, 1, 1, 1, 1, MODE_SYS),
              1'b0, '0);
      add_row(CORE_ARM7, blk(OP_STORE, 16'hFFFF, 4'd8, 32'h5555_5555, 0, 0, 1, 1, MODE_FIQ),
              1'b0, '0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed table; the core changes only once the block has drained.
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.core != core_sel) begin
            wait_drained();
            write_core(row.core);
         end
         send_block(row.instr, row.typed, row.beat);
      end

      // Random phases alternating the core; the last one runs without idling.
      for (int phase = 0; phase < 5; phase++) begin
         wait_drained();
         write_core(phase % 2 == 1 ? CORE_ARM7 : CORE_ARM9);
         idle_pct = (phase == 1 || phase == 4) ? 0 : 20 + 10 * phase;
         n_items = (phase == 4) ? 30 : 80;
         // Back-to-back instructions against a stalled result side fill the queue.
         if (phase == 1) long_hold_req = 1'b1;
         repeat (n_items) send_block(random_block(), 1'b0, '0);
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_transfers.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
